// ===== hdl/cia_pkg.sv =====
// Package with the shared types and constants of the checked 64-bit ALU.
`default_nettype none
package cia_pkg;

    localparam int DataWidth = 64;
    localparam int DivSteps  = DataWidth;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_DIVZERO  = 2'd2,
        ST_UNUSED   = 2'd3
    } status_t;

    localparam logic [DataWidth-1:0] Int64Min = {1'b1, {(DataWidth-1){1'b0}}};
    localparam logic [DataWidth-1:0] Int64Max = {1'b0, {(DataWidth-1){1'b1}}};
    localparam logic [DataWidth-1:0] MinusOne = {DataWidth{1'b1}};

    typedef struct packed {
        logic [1:0]                  op;
        logic signed [DataWidth-1:0] left_operand;
        logic signed [DataWidth-1:0] right_operand;
    } operands_t;

    typedef struct packed {
        logic signed [DataWidth-1:0] value;
        logic [1:0]                  status;
    } result_t;

    // Side information that travels with an item through the divider stages.
    typedef struct packed {
        op_t                  op;
        logic [DataWidth-1:0] value;
        status_t              status;
        logic                 neg;
    } aux_t;

endpackage
`default_nettype wire

// ===== hdl/checked_int64_alu_top.sv =====
// Top level of the checked signed 64-bit ALU.
//
// A command transfer happens at a rising edge where start is high and busy is
// low. The command carries an operation (add, subtract, multiply, divide) and
// two signed 64-bit operands. Every command produces exactly one result: a
// 64-bit value and a status (ok, overflow, division by zero). The value is zero
// whenever the status is not ok. Division truncates toward zero.
//
// The unit is a straight pipeline: an operand stage, two multiplier stages, a
// check stage, 64 divider stages (one quotient bit each) and an output stage.
// Every operation travels the full length, and done is high for one cycle
// with each result. A new command can be taken every cycle; throughput is one
// result per cycle, set by the pipelined divider which retires one quotient
// bit per stage.
//
// busy is always low, since the receiver cannot stall the result and the
// pipeline never has to hold. Reset clears all valid bits, dropping any
// commands in flight; no result appears for them.
`default_nettype none
module checked_int64_alu_top
    import cia_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire operands_t operands,
    output logic           done,
    output result_t        result
);

    // Stage 1: magnitudes, add/subtract and division checks.
    logic                 s1_valid_reg;
    logic [DataWidth-1:0] s1_mag_a_reg, s1_mag_b_reg;
    aux_t                 s1_aux_reg, s1_aux_next;
    logic [DataWidth-1:0] a_in, b_in, sum, diff;
    logic                 an, bn;

    assign busy = 1'b0;

    always_comb
    begin
        a_in = operands.left_operand;
        b_in = operands.right_operand;
        an   = a_in[DataWidth-1];
        bn   = b_in[DataWidth-1];
        sum  = a_in + b_in;
        diff = a_in - b_in;
        s1_aux_next.op     = op_t'(operands.op);
        s1_aux_next.neg    = an ^ bn;
        s1_aux_next.value  = '0;
        s1_aux_next.status = ST_OK;
        unique case (op_t'(operands.op))
            OP_ADD:
            begin
                if (an == bn && sum[DataWidth-1] != an)
                begin
                    s1_aux_next.status = ST_OVERFLOW;
                end
                else
                begin
                    s1_aux_next.value = sum;
                end
            end
            OP_SUB:
            begin
                if (an != bn && diff[DataWidth-1] != an)
                begin
                    s1_aux_next.status = ST_OVERFLOW;
                end
                else
                begin
                    s1_aux_next.value = diff;
                end
            end
            OP_MUL:
            begin
                s1_aux_next.status = ST_OK;
            end
            OP_DIV:
            begin
                if (b_in == '0)
                begin
                    s1_aux_next.status = ST_DIVZERO;
                end
                else if (a_in == Int64Min && b_in == MinusOne)
                begin
                    s1_aux_next.status = ST_OVERFLOW;
                end
            end
            default:
            begin
                s1_aux_next.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_mag_a_reg <= an ? (-a_in) : a_in;
        s1_mag_b_reg <= bn ? (-b_in) : b_in;
        s1_aux_reg   <= s1_aux_next;
    end

    // Stages 2 and 3: the multiplier, with the operands and flags alongside.
    logic [DataWidth-1:0] prod_hi, prod_lo;
    logic                 s2_valid_reg, s3_valid_reg;
    logic [DataWidth-1:0] s2_mag_a_reg, s2_mag_b_reg, s3_mag_a_reg, s3_mag_b_reg;
    aux_t                 s2_aux_reg, s3_aux_reg;

    cia_mul u_mul (
        .clk     (clk),
        .mag_a   (s1_mag_a_reg),
        .mag_b   (s1_mag_b_reg),
        .prod_hi (prod_hi),
        .prod_lo (prod_lo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_mag_a_reg <= s1_mag_a_reg;
        s2_mag_b_reg <= s1_mag_b_reg;
        s2_aux_reg   <= s1_aux_reg;
        s3_mag_a_reg <= s2_mag_a_reg;
        s3_mag_b_reg <= s2_mag_b_reg;
        s3_aux_reg   <= s2_aux_reg;
    end

    // Stage 4: product range check, then the item enters the divider.
    aux_t                 s4_aux_next;
    logic [DataWidth-1:0] mul_limit;

    always_comb
    begin
        s4_aux_next = s3_aux_reg;
        mul_limit   = s3_aux_reg.neg ? Int64Min : Int64Max;
        if (s3_aux_reg.op == OP_MUL)
        begin
            if (prod_hi != '0 || prod_lo > mul_limit)
            begin
                s4_aux_next.status = ST_OVERFLOW;
                s4_aux_next.value  = '0;
            end
            else
            begin
                s4_aux_next.value = s3_aux_reg.neg ? (-prod_lo) : prod_lo;
            end
        end
    end

    logic                 s4_valid_reg;
    logic [DataWidth-1:0] s4_mag_a_reg, s4_mag_b_reg;
    aux_t                 s4_aux_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_mag_a_reg <= s3_mag_a_reg;
        s4_mag_b_reg <= s3_mag_b_reg;
        s4_aux_reg   <= s4_aux_next;
    end

    logic                 div_valid;
    logic [DataWidth-1:0] quotient;
    aux_t                 div_aux;

    cia_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_valid_reg),
        .dividend  (s4_mag_a_reg),
        .divisor   (s4_mag_b_reg),
        .in_aux    (s4_aux_reg),
        .out_valid (div_valid),
        .quotient  (quotient),
        .out_aux   (div_aux)
    );

    // Output stage: the quotient takes its sign; other operations pass through.
    logic    done_reg;
    result_t result_reg, result_next;

    always_comb
    begin
        result_next.status = div_aux.status;
        result_next.value  = div_aux.value;
        if (div_aux.op == OP_DIV && div_aux.status == ST_OK)
        begin
            result_next.value = div_aux.neg ? (-quotient) : quotient;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // A failed operation never reports a nonzero value.
    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ST_OK |-> result.value == '0)
        else $error("nonzero value with error status");

    // The status code is never the unused one.
    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.status != ST_UNUSED)
        else $error("unused status code on result");

    // Every accepted command yields its result with done high.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##69 done)
        else $error("result missing after pipeline latency");

endmodule
`default_nettype wire

// ===== hdl/cia_mul.sv =====
// Two-stage unsigned 64x64 multiplier built from four 32x32 partial products.
`default_nettype none
module cia_mul
    import cia_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic [DataWidth-1:0] mag_a,
    input  wire logic [DataWidth-1:0] mag_b,
    output logic      [DataWidth-1:0] prod_hi,
    output logic      [DataWidth-1:0] prod_lo
);

    localparam int Half = DataWidth / 2;

    logic [DataWidth-1:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic [DataWidth-1:0] hi_reg, hi_next, lo_reg, lo_next;
    logic [Half+1:0]      mid;

    always_ff @(posedge clk)
    begin
        p00_reg <= DataWidth'(mag_a[Half-1:0])         * DataWidth'(mag_b[Half-1:0]);
        p01_reg <= DataWidth'(mag_a[Half-1:0])         * DataWidth'(mag_b[DataWidth-1:Half]);
        p10_reg <= DataWidth'(mag_a[DataWidth-1:Half]) * DataWidth'(mag_b[Half-1:0]);
        p11_reg <= DataWidth'(mag_a[DataWidth-1:Half]) * DataWidth'(mag_b[DataWidth-1:Half]);
    end

    always_comb
    begin
        mid = {2'b00, p00_reg[DataWidth-1:Half]} + {2'b00, p01_reg[Half-1:0]}
            + {2'b00, p10_reg[Half-1:0]};
        lo_next = {mid[Half-1:0], p00_reg[Half-1:0]};
        hi_next = p11_reg + {{Half{1'b0}}, p01_reg[DataWidth-1:Half]}
                + {{Half{1'b0}}, p10_reg[DataWidth-1:Half]}
                + {{(DataWidth-2){1'b0}}, mid[Half+1:Half]};
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign prod_hi = hi_reg;
    assign prod_lo = lo_reg;

endmodule
`default_nettype wire

// ===== hdl/cia_div.sv =====
// Fully pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module cia_div
    import cia_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic [DataWidth-1:0] dividend,
    input  wire logic [DataWidth-1:0] divisor,
    input  wire aux_t                 in_aux,
    output logic                      out_valid,
    output logic      [DataWidth-1:0] quotient,
    output aux_t                      out_aux
);

    logic                 valid_reg [DivSteps+1];
    logic [DataWidth-1:0] rem_reg   [DivSteps+1];
    logic [DataWidth-1:0] num_reg   [DivSteps+1];
    logic [DataWidth-1:0] den_reg   [DivSteps+1];
    aux_t                 aux_reg   [DivSteps+1];

    always_comb
    begin
        valid_reg[0] = in_valid;
        rem_reg[0]   = '0;
        num_reg[0]   = dividend;
        den_reg[0]   = divisor;
        aux_reg[0]   = in_aux;
    end

    for (genvar k = 0; k < DivSteps; k++)
    begin : g_step
        logic [DataWidth-1:0] shifted;
        logic                 fits;
        logic [DataWidth-1:0] rem_next;
        logic [DataWidth-1:0] num_next;

        always_comb
        begin
            shifted  = {rem_reg[k][DataWidth-2:0], num_reg[k][DataWidth-1]};
            fits     = shifted >= den_reg[k];
            rem_next = fits ? (shifted - den_reg[k]) : shifted;
            num_next = {num_reg[k][DataWidth-2:0], fits};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= rem_next;
            num_reg[k+1] <= num_next;
            den_reg[k+1] <= den_reg[k];
            aux_reg[k+1] <= aux_reg[k];
        end
    end

    assign out_valid = valid_reg[DivSteps];
    assign quotient  = num_reg[DivSteps];
    assign out_aux   = aux_reg[DivSteps];

endmodule
`default_nettype wire
